### hdl/brf_pkg.sv
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants for the binary record framer.
// ----------------------------------------------------------------------------
package brf_pkg;

   localparam int MAX_SIZE_BYTES_DEF = 4;

   localparam int BYTE_W = 8;
   localparam int KIND_W = 15;
   localparam int LEN_W  = 28;
   localparam int SEEN_W = 2;
   localparam int ROLE_W = 2;
   localparam int GROUP_W = 7;

   localparam logic [ROLE_W-1:0] ROLE_TYPE      = 2'd0;
   localparam logic [ROLE_W-1:0] ROLE_SIZE      = 2'd1;
   localparam logic [ROLE_W-1:0] ROLE_HDR_LAST  = 2'd2;
   localparam logic [ROLE_W-1:0] ROLE_PAYLOAD   = 2'd3;

   typedef enum logic [1:0] {
      PH_TYPE0   = 2'd0,
      PH_TYPE1   = 2'd1,
      PH_SIZE    = 2'd2,
      PH_PAYLOAD = 2'd3
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              stream_start;
   } req_type;

   typedef struct packed {
      logic [ROLE_W-1:0] byte_role;
      logic [KIND_W-1:0] record_kind;
      logic [LEN_W-1:0]  record_length;
      logic [LEN_W-1:0]  payload_index;
      logic [BYTE_W-1:0] out_byte;
      logic              record_done;
   } rsp_type;

   typedef struct packed {
      phase_type         phase;
      logic [KIND_W-1:0] type_acc;
      logic [LEN_W-1:0]  length_acc;
      logic [SEEN_W-1:0] length_bytes_seen;
      logic [LEN_W-1:0]  bytes_left;
      logic [LEN_W-1:0]  payload_pos;
   } state_type;

endpackage

### hdl/brf_step.sv
// ----------------------------------------------------------------------------
// brf_step
// Header and payload framing step: next parser state and result for one item.
// ----------------------------------------------------------------------------
module brf_step #(
   parameter int MAX_SIZE_BYTES = brf_pkg::MAX_SIZE_BYTES_DEF
) (
   input  brf_pkg::state_type state_cur,
   input  brf_pkg::req_type   req,
   output brf_pkg::state_type state_nxt,
   output brf_pkg::rsp_type   rsp
);
   import brf_pkg::*;

   localparam logic [SEEN_W:0] MaxSeen = (SEEN_W+1)'(MAX_SIZE_BYTES);

   phase_type         phase_eff;
   phase_type         phase_nxt;
   logic [LEN_W-1:0]  size_group;
   logic [LEN_W-1:0]  length_new;
   logic              size_last;
   logic [BYTE_W-1:0] b;

   assign b         = req.in_byte;
   assign phase_eff = req.stream_start ? PH_TYPE0 : state_cur.phase;

   always_comb begin
      unique case (state_cur.length_bytes_seen)
         2'd0:    size_group = {21'd0, b[GROUP_W-1:0]};
         2'd1:    size_group = {14'd0, b[GROUP_W-1:0], 7'd0};
         2'd2:    size_group = {7'd0, b[GROUP_W-1:0], 14'd0};
         default: size_group = {b[GROUP_W-1:0], 21'd0};
      endcase
   end

   assign length_new = state_cur.length_acc | size_group;
   assign size_last  = !b[BYTE_W-1] ||
                       (({1'b0, state_cur.length_bytes_seen} + 3'd1) >= MaxSeen);

   // next phase
   always_comb begin
      unique case (phase_eff)
         PH_TYPE0:   phase_nxt = b[BYTE_W-1] ? PH_TYPE1 : PH_SIZE;
         PH_TYPE1:   phase_nxt = PH_SIZE;
         PH_SIZE: begin
            if (!size_last)
               phase_nxt = PH_SIZE;
            else if (length_new == '0)
               phase_nxt = PH_TYPE0;
            else
               phase_nxt = PH_PAYLOAD;
         end
         default:    phase_nxt = (state_cur.bytes_left <= LEN_W'(1)) ?
                                 PH_TYPE0 : PH_PAYLOAD;
      endcase
   end

   // accumulators and result
   always_comb begin
      state_nxt.phase             = phase_nxt;
      state_nxt.type_acc          = state_cur.type_acc;
      state_nxt.length_acc        = state_cur.length_acc;
      state_nxt.length_bytes_seen = state_cur.length_bytes_seen;
      state_nxt.bytes_left        = state_cur.bytes_left;
      state_nxt.payload_pos       = state_cur.payload_pos;
      rsp.byte_role     = ROLE_TYPE;
      rsp.payload_index = '0;
      rsp.record_done   = 1'b0;
      unique case (phase_eff)
         PH_TYPE0: begin
            state_nxt.type_acc          = {8'd0, b[GROUP_W-1:0]};
            state_nxt.length_acc        = '0;
            state_nxt.length_bytes_seen = '0;
            state_nxt.bytes_left        = '0;
            state_nxt.payload_pos       = '0;
         end
         PH_TYPE1: begin
            state_nxt.type_acc = {b, state_cur.type_acc[GROUP_W-1:0]};
         end
         PH_SIZE: begin
            state_nxt.length_acc = length_new;
            if (size_last) begin
               rsp.byte_role               = ROLE_HDR_LAST;
               state_nxt.length_bytes_seen = '0;
               state_nxt.payload_pos       = '0;
               if (length_new == '0)
                  rsp.record_done = 1'b1;
               else
                  state_nxt.bytes_left = length_new;
            end else begin
               rsp.byte_role               = ROLE_SIZE;
               state_nxt.length_bytes_seen = state_cur.length_bytes_seen + 2'd1;
            end
         end
         default: begin
            rsp.byte_role         = ROLE_PAYLOAD;
            rsp.payload_index     = state_cur.payload_pos;
            state_nxt.payload_pos = state_cur.payload_pos + LEN_W'(1);
            if (state_cur.bytes_left <= LEN_W'(1)) begin
               state_nxt.bytes_left = '0;
               rsp.record_done      = 1'b1;
            end else begin
               state_nxt.bytes_left = state_cur.bytes_left - LEN_W'(1);
            end
         end
      endcase
      rsp.record_kind   = state_nxt.type_acc;
      rsp.record_length = state_nxt.length_acc;
      rsp.out_byte      = b;
   end

endmodule

### hdl/binary_record_framer_top.sv
// ----------------------------------------------------------------------------
// binary_record_framer_top
// Frames a byte stream of type/size-headed records, one result per byte.
// ----------------------------------------------------------------------------
// Takes one byte per clock and returns one result per byte in the cycle after
// the byte is taken. The parser state and the result register are both
// updated in the cycle of acceptance, so bytes stream back to back; the only
// pause comes from rsp_stall while the result register is full and not
// being taken. The size field is one to MAX_SIZE_BYTES 7-bit groups.
module binary_record_framer_top #(
   parameter int MAX_SIZE_BYTES = brf_pkg::MAX_SIZE_BYTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  brf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output brf_pkg::rsp_type rsp_data
);
   import brf_pkg::*;

   state_type state_ff, state_in;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;

   brf_step #(
      .MAX_SIZE_BYTES(MAX_SIZE_BYTES)
   ) u_step (
      .state_cur(state_ff),
      .req      (req_data),
      .state_nxt(state_in),
      .rsp      (rsp_in)
   );

   always_comb begin
      if (take)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase             <= PH_TYPE0;
         state_ff.type_acc          <= '0;
         state_ff.length_acc        <= '0;
         state_ff.length_bytes_seen <= '0;
         state_ff.bytes_left        <= '0;
         state_ff.payload_pos       <= '0;
         rsp_valid_ff               <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take)
            state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take)
         rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_payload_left: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_PAYLOAD |-> state_ff.bytes_left != '0)
      else $error("payload phase with no bytes left");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_SIZE |->
         ({1'b0, state_ff.length_bytes_seen} < (SEEN_W+1)'(MAX_SIZE_BYTES)))
      else $error("size byte count beyond limit");

   a_type_no_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.byte_role == ROLE_TYPE |-> !rsp_ff.record_done)
      else $error("type byte marked as record end");

   a_take_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid_ff)
      else $error("accepted item produced no result");

endmodule

### dv/binary_record_framer_tb.sv
// ----------------------------------------------------------------------------
// binary_record_framer_tb
// Self-checking bench for the binary record framer.
// ----------------------------------------------------------------------------
// Sends a byte stream into binary_record_framer_top and predicts the framing
// of every accepted byte: role, record type, record size, payload offset and
// record end. Each result taken from the block is compared field by field
// with the oldest prediction. Directed records cover one- and two-byte types,
// empty records, a size field cut short after four bytes and restarts in the
// middle of a header or a payload. Random records with random types, sizes
// and contents follow, mixed with truncated records and stray bytes, while
// both sides pause at random and the receiver once holds off for a long time.
// ----------------------------------------------------------------------------
module tb;
   import brf_pkg::*;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type           expected_frames[$];
   phase_type         fr_phase   = PH_TYPE0;
   logic [KIND_W-1:0] fr_kind    = '0;
   logic [LEN_W-1:0]  fr_length  = '0;
   logic [SEEN_W-1:0] fr_groups  = '0;
   logic [LEN_W-1:0]  fr_left    = '0;
   logic [LEN_W-1:0]  fr_offset  = '0;

   int mismatches      = 0;
   int items_sent      = 0;
   int hold_off_cycles = 0;
   bit tx_idle_on      = 1'b0;
   bit rx_idle_on      = 1'b0;
   bit resync_needed   = 1'b0;

   binary_record_framer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("** binary_record_framer_top: FAILED **");
      $finish;
   end

   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // predict the framing of one accepted byte
   task automatic frame_byte(input req_type item);
      rsp_type      exp;
      logic [1:0]   seen;
      logic         last;
      exp = '0;
      exp.out_byte = item.in_byte;
      if (item.stream_start) fr_phase = PH_TYPE0;
      case (fr_phase)
         PH_TYPE0: begin
            fr_kind   = {8'd0, item.in_byte[6:0]};
            fr_length = '0;
            fr_groups = '0;
            fr_left   = '0;
            fr_offset = '0;
            exp.byte_role = ROLE_TYPE;
            fr_phase = item.in_byte[7] ? PH_TYPE1 : PH_SIZE;
         end
         PH_TYPE1: begin
            fr_kind = {item.in_byte, fr_kind[6:0]};
            exp.byte_role = ROLE_TYPE;
            fr_phase = PH_SIZE;
         end
         PH_SIZE: begin
            seen = fr_groups;
            fr_length = fr_length | ({21'd0, item.in_byte[6:0]} << (GROUP_W * seen));
            last = !item.in_byte[7] || (int'(seen) + 1 >= MAX_SIZE_BYTES_DEF);
            if (last) begin
               exp.byte_role = ROLE_HDR_LAST;
               fr_groups = '0;
               fr_offset = '0;
               if (fr_length == '0) begin
                  exp.record_done = 1'b1;
                  fr_phase = PH_TYPE0;
               end else begin
                  fr_left  = fr_length;
                  fr_phase = PH_PAYLOAD;
               end
            end else begin
               exp.byte_role = ROLE_SIZE;
               fr_groups = seen + 2'd1;
            end
         end
         default: begin
            exp.byte_role     = ROLE_PAYLOAD;
            exp.payload_index = fr_offset;
            fr_offset = fr_offset + LEN_W'(1);
            if (fr_left <= LEN_W'(1)) begin
               fr_left = '0;
               exp.record_done = 1'b1;
               fr_phase = PH_TYPE0;
            end else begin
               fr_left = fr_left - LEN_W'(1);
            end
         end
      endcase
      exp.record_kind   = fr_kind;
      exp.record_length = fr_length;
      expected_frames = {expected_frames, exp};
   endtask

   // entered and left at a falling edge; valid stays high for the next item
   task automatic send_item(input logic [BYTE_W-1:0] value, input logic restart);
      req_type item;
      int      gap;
      item.in_byte      = value;
      item.stream_start = restart;
      gap = tx_idle_on ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      frame_byte(item);
      items_sent++;
      @(negedge clock);
   endtask

   // one well-formed record with random content, sometimes cut off
   task automatic send_random_record();
      req_type           stream_q[$];
      req_type           it;
      logic [KIND_W-1:0] kind;
      logic [LEN_W-1:0]  length;
      logic [LEN_W-1:0]  grp;
      int                pick, needed, groups, total, keep, body;
      bit                two_byte, cut;
      kind = $urandom_range(0, 1) ? KIND_W'($urandom_range(0, 127))
                                  : KIND_W'($urandom_range(0, 32767));
      two_byte = (kind[14:7] != 0) || ($urandom_range(0, 7) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 15)      length = '0;
      else if (pick < 85) length = LEN_W'($urandom_range(1, 12));
      else if (pick < 97) length = LEN_W'($urandom_range(13, 200));
      else                length = LEN_W'($urandom_range(201, 28'hFFF_FFFF));
      needed = 1;
      while (needed < MAX_SIZE_BYTES_DEF && (length >> (GROUP_W * needed)) != 0) needed++;
      groups = ($urandom_range(0, 5) == 0) ? $urandom_range(needed, MAX_SIZE_BYTES_DEF)
                                           : needed;
      it.stream_start = 1'b0;
      if (two_byte) begin
         it.in_byte = {1'b1, kind[6:0]};
         stream_q = {stream_q, it};
         it.in_byte = kind[14:7];
         stream_q = {stream_q, it};
      end else begin
         it.in_byte = {1'b0, kind[6:0]};
         stream_q = {stream_q, it};
      end
      for (int g = 0; g < groups; g++) begin
         grp = length >> (GROUP_W * g);
         if (g < groups - 1)                    it.in_byte = {1'b1, grp[6:0]};
         else if (g == MAX_SIZE_BYTES_DEF - 1)  it.in_byte = {1'($urandom_range(0, 1)), grp[6:0]};
         else                                   it.in_byte = {1'b0, grp[6:0]};
         stream_q = {stream_q, it};
      end
      body = (length > 200) ? 200 : int'(length);
      for (int i = 0; i < body; i++) begin
         it.in_byte = BYTE_W'($urandom_range(0, 255));
         stream_q = {stream_q, it};
      end
      total = stream_q.size();
      cut   = (length > 200) || ($urandom_range(0, 19) == 0);
      keep  = cut ? $urandom_range(1, total - 1) : total;
      stream_q[0].stream_start = resync_needed || ($urandom_range(0, 9) == 0);
      for (int i = 0; i < keep; i++)
         send_item(stream_q[i].in_byte, stream_q[i].stream_start);
      resync_needed = cut;
   endtask

   task automatic test_single_byte_type();
      send_item(8'h01, 1'b0);
      send_item(8'h03, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h5A, 1'b0);
   endtask

   // widest type, then an empty record ending on its header
   task automatic test_two_byte_type();
      send_item(8'hFF, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
   endtask

   // four size bytes end the header whatever the last continuation bit says
   task automatic test_size_cut_short();
      send_item(8'h7F, 1'b0);
      repeat (4) send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b1);
      send_item(8'h81, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'hAA, 1'b0);
   endtask

   // drop a partial header, then a partial payload
   task automatic test_restart();
      send_item(8'h12, 1'b1);
      send_item(8'h82, 1'b0);
      send_item(8'h05, 1'b1);
      send_item(8'h02, 1'b0);
      send_item(8'h11, 1'b0);
      send_item(8'h00, 1'b1);
      send_item(8'h00, 1'b0);
   endtask

   // hold the receiver off while the sender keeps offering bytes
   task automatic test_output_backpressure();
      int start_count;
      tx_idle_on = 1'b0;
      hold_off_cycles = 300;
      start_count = items_sent;
      while (items_sent - start_count < 40) send_random_record();
   endtask

   task automatic test_random_stream();
      int stop_at;
      stop_at = items_sent + 1900;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 39) == 0) begin
            tx_idle_on = $urandom_range(0, 2) != 0;
            rx_idle_on = $urandom_range(0, 2) != 0;
         end
         if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 6))
               send_item(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            resync_needed = 1'b1;
         end else begin
            send_random_record();
         end
      end
   endtask

   initial begin : receiver
      int stall_run;
      stall_run = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else if (!rx_idle_on) begin
            rsp_stall <= 1'b0;
         end else if (stall_run > 0) begin
            rsp_stall <= 1'b1;
            stall_run--;
         end else begin
            stall_run = idle_length();
            rsp_stall <= (stall_run > 0);
            if (stall_run > 0) stall_run--;
         end
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type exp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: role %0d kind %h len %h idx %h byte %h done %b",
                        rsp_data.byte_role, rsp_data.record_kind, rsp_data.record_length,
                        rsp_data.payload_index, rsp_data.out_byte, rsp_data.record_done);
         end else begin
            exp = expected_frames.pop_front();
            if (rsp_data.byte_role     !== exp.byte_role     ||
                rsp_data.record_kind   !== exp.record_kind   ||
                rsp_data.record_length !== exp.record_length ||
                rsp_data.payload_index !== exp.payload_index ||
                rsp_data.out_byte      !== exp.out_byte      ||
                rsp_data.record_done   !== exp.record_done) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp role %0d kind %h len %h idx %h byte %h done %b",
                           exp.byte_role, exp.record_kind, exp.record_length,
                           exp.payload_index, exp.out_byte, exp.record_done);
                  $display("          got role %0d kind %h len %h idx %h byte %h done %b",
                           rsp_data.byte_role, rsp_data.record_kind, rsp_data.record_length,
                           rsp_data.payload_index, rsp_data.out_byte, rsp_data.record_done);
               end
            end
         end
      end
   end

   initial begin : main
      int waited;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      test_single_byte_type();
      test_two_byte_type();
      test_size_cut_short();
      test_restart();
      test_output_backpressure();
      test_random_stream();
      req_valid <= 1'b0;
      waited = 0;
      while (expected_frames.size() != 0 && waited < 2000) begin
         @(negedge clock);
         waited++;
      end
      repeat (8) @(negedge clock);
      if (expected_frames.size() != 0) begin
         $display("%0d items never returned", expected_frames.size());
         mismatches += expected_frames.size();
      end
      if (mismatches == 0) begin
         $display("** binary_record_framer_top: PASSED **");
      end else begin
         $display("** binary_record_framer_top: FAILED **");
      end
      $finish;
   end

endmodule
